// ===== hdl/lsbm_pkg.sv =====
`timescale 1ns / 1ps

package lsbm_pkg;

	// default lattice size
	localparam int unsigned GRID_X_DEF = 16;
	localparam int unsigned GRID_Y_DEF = 16;
	localparam int unsigned GRID_Z_DEF = 16;

	localparam int unsigned COORD_W = 4;
	localparam int unsigned MCOORD_W = COORD_W + 1; // coordinate after a +1 move
	localparam int unsigned DIR_W = 5;
	localparam int unsigned IDX_W = 17;
	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned CLAMP_W = 31;
	localparam int unsigned GRID_W = 9;             // holds grid sizes up to 511

	localparam int unsigned IN_W = 56;   // 49 payload bits padded to bytes
	localparam int unsigned OUT_W = 72;  // 65 payload bits padded to bytes

	localparam logic [DIR_W-1:0] DIR_REST = 5'd0;
	localparam logic [DIR_W-1:0] DIR_LAST = 5'd18;

	// axis masks, bit 0 = x, bit 1 = y, bit 2 = z
	typedef struct packed {
		logic [2:0]       pos;
		logic [2:0]       neg;
		logic [DIR_W-1:0] only_a;
		logic [DIR_W-1:0] only_b;
		logic [DIR_W-1:0] neither;
	} dir_entry_t;

	// stage 1: saturated cell, decoded direction, per-axis move permission
	typedef struct packed {
		logic [2:0][COORD_W-1:0] coord;
		logic [DIR_W-1:0]        dir;
		dir_entry_t              ent;
		logic [2:0]              ok;
		logic [CLAMP_W-1:0]      clamped;
	} dec_t;

	// stage 2: moved cell and remapped direction
	typedef struct packed {
		logic [2:0][MCOORD_W-1:0] coord;
		logic [DIR_W-1:0]         odir;
		logic [CLAMP_W-1:0]       clamped;
	} mov_t;

	// stage 3: partial index terms
	typedef struct packed {
		logic [2:0][MCOORD_W-1:0] coord;
		logic [DIR_W-1:0]         odir;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         dterm;
		logic [CLAMP_W-1:0]       clamped;
	} part_t;

	// stage 4: finished result
	typedef struct packed {
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic [COORD_W-1:0] dest_z;
		logic [DIR_W-1:0]   dest_direction;
		logic [IDX_W-1:0]   dest_index;
		logic [CLAMP_W-1:0] clamped_sample;
	} res_t;

	// D3Q19 velocity set with edge remaps; unknown codes act as rest
	function automatic dir_entry_t dir_lookup(input logic [DIR_W-1:0] d);
		dir_entry_t e;
		unique case (d)
			5'd1:    e = '{3'b001, 3'b000, 5'd0,  5'd0,  5'd2};
			5'd2:    e = '{3'b000, 3'b001, 5'd0,  5'd0,  5'd1};
			5'd3:    e = '{3'b010, 3'b000, 5'd0,  5'd0,  5'd4};
			5'd4:    e = '{3'b000, 3'b010, 5'd0,  5'd0,  5'd3};
			5'd5:    e = '{3'b100, 3'b000, 5'd0,  5'd0,  5'd6};
			5'd6:    e = '{3'b000, 3'b100, 5'd0,  5'd0,  5'd5};
			5'd7:    e = '{3'b011, 3'b000, 5'd9,  5'd10, 5'd8};
			5'd8:    e = '{3'b000, 3'b011, 5'd9,  5'd10, 5'd7};
			5'd9:    e = '{3'b010, 3'b001, 5'd8,  5'd7,  5'd10};
			5'd10:   e = '{3'b001, 3'b010, 5'd8,  5'd7,  5'd9};
			5'd11:   e = '{3'b101, 3'b000, 5'd16, 5'd15, 5'd12};
			5'd12:   e = '{3'b000, 3'b101, 5'd15, 5'd16, 5'd11};
			5'd13:   e = '{3'b110, 3'b000, 5'd18, 5'd17, 5'd14};
			5'd14:   e = '{3'b000, 3'b110, 5'd17, 5'd18, 5'd13};
			5'd15:   e = '{3'b100, 3'b001, 5'd12, 5'd11, 5'd16};
			5'd16:   e = '{3'b001, 3'b100, 5'd11, 5'd12, 5'd15};
			5'd17:   e = '{3'b100, 3'b010, 5'd14, 5'd13, 5'd18};
			5'd18:   e = '{3'b010, 3'b100, 5'd13, 5'd14, 5'd17};
			default: e = '{3'b000, 3'b000, 5'd0,  5'd0,  5'd0};
		endcase
		return e;
	endfunction

	function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] c,
			input logic [GRID_W-1:0] n);
		logic [GRID_W-1:0] nm1;
		nm1 = n - 1'b1;
		if ({{(GRID_W-COORD_W){1'b0}}, c} >= n) begin
			return nm1[COORD_W-1:0];
		end
		return c;
	endfunction

endpackage

// ===== hdl/lsbm_decode.sv =====
`timescale 1ns / 1ps

module lsbm_decode import lsbm_pkg::*; #(
	parameter int unsigned GRID_X = GRID_X_DEF,
	parameter int unsigned GRID_Y = GRID_Y_DEF,
	parameter int unsigned GRID_Z = GRID_Z_DEF
) (
	input  logic            clk,
	input  logic            en,
	input  logic [IN_W-1:0] req_data,
	output dec_t            dec_s1
);

	localparam logic [2:0][GRID_W-1:0] GRID = {GRID_W'(GRID_Z), GRID_W'(GRID_Y),
		GRID_W'(GRID_X)};

	logic [2:0][COORD_W-1:0] raw;
	logic [DIR_W-1:0]        dir_in;
	logic [SAMPLE_W-1:0]     sample;
	dec_t                    nxt;

	assign raw[0] = req_data[3:0];
	assign raw[1] = req_data[7:4];
	assign raw[2] = req_data[11:8];
	assign dir_in = req_data[16:12];
	assign sample = req_data[48:17];

	always_comb begin
		nxt = '0;
		for (int k = 0; k < 3; k++) begin
			nxt.coord[k] = sat_coord(raw[k], GRID[k]);
		end
		nxt.dir = (dir_in > DIR_LAST) ? DIR_REST : dir_in;
		nxt.ent = dir_lookup(nxt.dir);
		for (int k = 0; k < 3; k++) begin
			// +1 needs room below the far wall, -1 needs room above zero
			nxt.ok[k] = 1'b1;
			if (nxt.ent.pos[k]) begin
				nxt.ok[k] = {{(GRID_W-COORD_W){1'b0}}, nxt.coord[k]} < (GRID[k] - 1'b1);
			end else if (nxt.ent.neg[k]) begin
				nxt.ok[k] = (nxt.coord[k] != '0);
			end
		end
		nxt.clamped = sample[SAMPLE_W-1] ? '0 : sample[CLAMP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= nxt;
		end
	end

endmodule

// ===== hdl/lsbm_move.sv =====
`timescale 1ns / 1ps

module lsbm_move import lsbm_pkg::*; (
	input  logic clk,
	input  logic en,
	input  dec_t dec_s1,
	output mov_t mov_s2
);

	logic [2:0] mv;
	logic [2:0] first_ax;
	logic [2:0] second_ax;
	logic [2:0] apply;
	logic       ok_a;
	logic       ok_b;
	logic       diag;
	mov_t       nxt;

	assign mv = dec_s1.ent.pos | dec_s1.ent.neg;
	// axes of a diagonal taken in x, y, z order
	assign first_ax[0] = mv[0];
	assign first_ax[1] = mv[1] & ~mv[0];
	assign first_ax[2] = mv[2] & ~mv[1] & ~mv[0];
	assign second_ax = mv & ~first_ax;
	assign diag = |second_ax;
	assign ok_a = |(first_ax & dec_s1.ok);
	assign ok_b = |(second_ax & dec_s1.ok);

	always_comb begin
		nxt = '0;
		nxt.clamped = dec_s1.clamped;
		nxt.odir = dec_s1.dir;
		apply = '0;
		if (!diag) begin
			apply = mv & dec_s1.ok;
			if (mv != '0 && !ok_a) begin
				nxt.odir = dec_s1.ent.neither;
			end
		end else begin
			priority if (ok_a && ok_b) begin
				apply = mv;
			end else if (ok_a) begin
				apply = first_ax;
				nxt.odir = dec_s1.ent.only_a;
			end else if (ok_b) begin
				apply = second_ax;
				nxt.odir = dec_s1.ent.only_b;
			end else begin
				nxt.odir = dec_s1.ent.neither;
			end
		end
		for (int k = 0; k < 3; k++) begin
			nxt.coord[k] = {1'b0, dec_s1.coord[k]};
			if (apply[k] && dec_s1.ent.pos[k]) begin
				nxt.coord[k] = nxt.coord[k] + 1'b1;
			end else if (apply[k]) begin
				nxt.coord[k] = nxt.coord[k] - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mov_s2 <= nxt;
		end
	end

endmodule

// ===== hdl/lsbm_index.sv =====
`timescale 1ns / 1ps

module lsbm_index import lsbm_pkg::*; #(
	parameter int unsigned GRID_X = GRID_X_DEF,
	parameter int unsigned GRID_Y = GRID_Y_DEF,
	parameter int unsigned GRID_Z = GRID_Z_DEF
) (
	input  logic clk,
	input  logic en3,
	input  logic en4,
	input  mov_t mov_s2,
	output res_t res_s4
);

	// everything is taken mod 2^IDX_W, so constants are cut to that width
	localparam logic [IDX_W-1:0] STRIDE_Y = IDX_W'(GRID_Y);
	localparam logic [IDX_W-1:0] STRIDE_X = IDX_W'(GRID_X);
	localparam logic [IDX_W-1:0] DIR_STRIDE =
		IDX_W'((64'(GRID_X) * 64'(GRID_Y) * 64'(GRID_Z)) % (64'd1 << IDX_W));

	part_t part_s3;
	part_t part_nxt;
	res_t  res_nxt;

	always_comb begin
		part_nxt = '0;
		part_nxt.coord = mov_s2.coord;
		part_nxt.odir = mov_s2.odir;
		part_nxt.clamped = mov_s2.clamped;
		part_nxt.row = IDX_W'(mov_s2.coord[1]) + IDX_W'(mov_s2.coord[2]) * STRIDE_Y;
		part_nxt.dterm = IDX_W'(mov_s2.odir) * DIR_STRIDE;
	end

	always_comb begin
		res_nxt = '0;
		res_nxt.dest_x = part_s3.coord[0][COORD_W-1:0];
		res_nxt.dest_y = part_s3.coord[1][COORD_W-1:0];
		res_nxt.dest_z = part_s3.coord[2][COORD_W-1:0];
		res_nxt.dest_direction = part_s3.odir;
		res_nxt.dest_index = IDX_W'(part_s3.coord[0]) + part_s3.row * STRIDE_X
			+ part_s3.dterm;
		res_nxt.clamped_sample = part_s3.clamped;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			part_s3 <= part_nxt;
		end
		if (en4) begin
			res_s4 <= res_nxt;
		end
	end

endmodule

// ===== hdl/lattice_stream_boundary_map.sv =====
`timescale 1ns / 1ps

// D3Q19 streaming map with wall bounce-back, one distribution value per request.
//
// Slave channel (s_axis_*): one request carries a source cell, a direction and
// a signed Q16.16 sample. Master channel (m_axis_*): one response per request,
// in order: destination cell, destination direction, linear destination index
// and the sample clamped at zero.
//
// Pipeline: an accepted request passes through four register stages (decode,
// move, partial index products, final index sum / output register) on its way
// to m_axis_tvalid. Throughput: one request per clock while m_axis_tready is
// high; each of the four stages holds one request.
// Stall: the per-stage ready chain lets bubbles collapse; when m_axis_tready is
// low a full pipe holds every request in place and s_axis_tready drops only
// once all four stages are occupied.
// Reset: arst_n clears the stage valid bits, so the pipe comes up empty and
// ready. The stage data registers have no reset; there is nothing to configure.
// Coordinates beyond the grid saturate to the last cell; direction codes above
// 18 are treated as the rest direction.

module lattice_stream_boundary_map import lsbm_pkg::*; #(
	parameter int unsigned GRID_X = GRID_X_DEF,
	parameter int unsigned GRID_Y = GRID_Y_DEF,
	parameter int unsigned GRID_Z = GRID_Z_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// cell_x[3:0], cell_y[7:4], cell_z[11:8], direction[16:12], sample[48:17]
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// dest_x[3:0], dest_y[7:4], dest_z[11:8], dest_direction[16:12],
	// dest_index[33:17], clamped_sample[64:34]
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	dec_t dec_s1;
	mov_t mov_s2;
	res_t res_s4;

	// a stage loads when it is empty or its contents move on this cycle
	assign rdy4 = !valid_s4 || m_axis_tready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_axis_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	lsbm_decode #(
		.GRID_X(GRID_X),
		.GRID_Y(GRID_Y),
		.GRID_Z(GRID_Z)
	) u_decode (
		.clk     (clk),
		.en      (rdy1),
		.req_data(s_axis_tdata),
		.dec_s1  (dec_s1)
	);

	lsbm_move u_move (
		.clk   (clk),
		.en    (rdy2),
		.dec_s1(dec_s1),
		.mov_s2(mov_s2)
	);

	lsbm_index #(
		.GRID_X(GRID_X),
		.GRID_Y(GRID_Y),
		.GRID_Z(GRID_Z)
	) u_index (
		.clk   (clk),
		.en3   (rdy3),
		.en4   (rdy4),
		.mov_s2(mov_s2),
		.res_s4(res_s4)
	);

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata = {7'd0, res_s4.clamped_sample, res_s4.dest_index,
		res_s4.dest_direction, res_s4.dest_z, res_s4.dest_y, res_s4.dest_x};

	// backpressure reaches the input only with every stage full
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("input stalled with a bubble in the pipe");

	// a stalled request in stage 3 stays there
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !rdy3) |=> valid_s3)
		else $error("stage 3 request lost under stall");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res_s4.dest_direction <= DIR_LAST))
		else $error("destination direction out of range");

	// for grids that fit the 4-bit fields the destination is always inside
	a_dest_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((GRID_X > 16) || (32'(res_s4.dest_x) < GRID_X))
			&& ((GRID_Y > 16) || (32'(res_s4.dest_y) < GRID_Y))
			&& ((GRID_Z > 16) || (32'(res_s4.dest_z) < GRID_Z)))
		else $error("destination cell outside grid");

endmodule

// ===== test/lattice_stream_boundary_map_tb.sv =====
`timescale 1ns / 1ps

// Streams cell/direction/sample requests into the D3Q19 boundary map and checks
// every response against an in-bench model of the streaming and wall rules.
module lattice_stream_boundary_map_tb;
	import lsbm_pkg::*;

	localparam int unsigned GRID_X = GRID_X_DEF;
	localparam int unsigned GRID_Y = GRID_Y_DEF;
	localparam int unsigned GRID_Z = GRID_Z_DEF;
	localparam int unsigned PAD_W = IN_W - 49;

	localparam int RANDOM_REQUESTS = 1200;
	localparam int STALL_CYCLES = 60;       // long receiver hold-off
	localparam int DRAIN_CYCLES = 20;       // pipe is 4 deep, plenty of margin

	// D3Q19 direction codes, named after their velocity vector
	typedef enum logic [DIR_W-1:0] {
		D_REST, D_PX, D_NX, D_PY, D_NY, D_PZ, D_NZ,
		D_PXPY, D_NXNY, D_NXPY, D_PXNY,
		D_PXPZ, D_NXNZ, D_PYPZ, D_NYNZ,
		D_NXPZ, D_PXNZ, D_NYPZ, D_PYNZ
	} dir_e;

	// out-of-range codes, both act as rest
	localparam logic [DIR_W-1:0] DIR_BAD_LO = 5'd19;
	localparam logic [DIR_W-1:0] DIR_BAD_HI = 5'd31;

	// request fields, lowest tdata bits last in the struct
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [DIR_W-1:0]    dir;
		logic [COORD_W-1:0]  z;
		logic [COORD_W-1:0]  y;
		logic [COORD_W-1:0]  x;
	} request_t;

	// response fields, same layout as m_axis_tdata[64:0]
	typedef struct packed {
		logic [CLAMP_W-1:0] clamp;
		logic [IDX_W-1:0]   idx;
		logic [DIR_W-1:0]   dir;
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} dest_t;

	// step per axis plus the remaps for partial and full blockage
	typedef struct packed {
		int dx;
		int dy;
		int dz;
		int only_a;
		int only_b;
		int neither;
	} hop_t;

	typedef struct {
		request_t req;
		bit       fixed;   // use want as typed, skip the model
		dest_t    want;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	dest_t     pending_dest[$];   // predicted responses, oldest first
	plan_row_t plan[$];           // directed requests
	int        mismatches = 0;
	bit        calm = 1'b0;       // no idling on either side while set
	int        stall_ask = 0;     // bumped by stimulus to request a hold-off
	int        stall_seen = 0;
	int        hold_left = 0;

	lattice_stream_boundary_map #(
		.GRID_X(GRID_X),
		.GRID_Y(GRID_Y),
		.GRID_Z(GRID_Z)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// axis order is x, y, z: "a" is the first moving axis, "b" the second
	function automatic hop_t hop_of(input dir_e d);
		case (d)
			D_PX:    return '{ 1,  0,  0, 0, 0, D_NX};
			D_NX:    return '{-1,  0,  0, 0, 0, D_PX};
			D_PY:    return '{ 0,  1,  0, 0, 0, D_NY};
			D_NY:    return '{ 0, -1,  0, 0, 0, D_PY};
			D_PZ:    return '{ 0,  0,  1, 0, 0, D_NZ};
			D_NZ:    return '{ 0,  0, -1, 0, 0, D_PZ};
			D_PXPY:  return '{ 1,  1,  0, D_NXPY, D_PXNY, D_NXNY};
			D_NXNY:  return '{-1, -1,  0, D_NXPY, D_PXNY, D_PXPY};
			D_NXPY:  return '{-1,  1,  0, D_NXNY, D_PXPY, D_PXNY};
			D_PXNY:  return '{ 1, -1,  0, D_NXNY, D_PXPY, D_NXPY};
			D_PXPZ:  return '{ 1,  0,  1, D_PXNZ, D_NXPZ, D_NXNZ};
			D_NXNZ:  return '{-1,  0, -1, D_NXPZ, D_PXNZ, D_PXPZ};
			D_PYPZ:  return '{ 0,  1,  1, D_PYNZ, D_NYPZ, D_NYNZ};
			D_NYNZ:  return '{ 0, -1, -1, D_NYPZ, D_PYNZ, D_PYPZ};
			D_NXPZ:  return '{-1,  0,  1, D_NXNZ, D_PXPZ, D_PXNZ};
			D_PXNZ:  return '{ 1,  0, -1, D_PXPZ, D_NXNZ, D_NXPZ};
			D_NYPZ:  return '{ 0, -1,  1, D_NYNZ, D_PYPZ, D_PYNZ};
			D_PYNZ:  return '{ 0,  1, -1, D_PYPZ, D_NYNZ, D_NYPZ};
			default: return '{ 0,  0,  0, 0, 0, D_REST};
		endcase
	endfunction

	// Where a value lands after one streaming step with bounce-back at walls.
	function automatic dest_t stream_dest(input request_t r);
		hop_t        h;
		int          pos[3];
		int          lim[3];
		int          mv[3];
		bit          fits[3];
		int          ax[2];
		int          naxes;
		int          odir;
		int unsigned flat;
		logic [DIR_W-1:0] code;
		dest_t       res;
		lim[0] = GRID_X;
		lim[1] = GRID_Y;
		lim[2] = GRID_Z;
		// coordinates past the grid pin to the last cell
		pos[0] = (r.x >= GRID_X) ? GRID_X - 1 : r.x;
		pos[1] = (r.y >= GRID_Y) ? GRID_Y - 1 : r.y;
		pos[2] = (r.z >= GRID_Z) ? GRID_Z - 1 : r.z;
		code = (r.dir > DIR_LAST) ? DIR_REST : r.dir;
		h = hop_of(dir_e'(code));
		mv[0] = h.dx;
		mv[1] = h.dy;
		mv[2] = h.dz;
		naxes = 0;
		for (int k = 0; k < 3; k++) begin
			if (mv[k] > 0) begin
				fits[k] = pos[k] < lim[k] - 1;
			end else if (mv[k] < 0) begin
				fits[k] = pos[k] > 0;
			end else begin
				fits[k] = 1'b1;
			end
			if (mv[k] != 0 && naxes < 2) begin
				ax[naxes] = k;
				naxes++;
			end
		end
		odir = code;
		if (naxes == 1) begin
			if (fits[ax[0]]) pos[ax[0]] += mv[ax[0]];
			else odir = h.neither;
		end else if (naxes == 2) begin
			if (fits[ax[0]] && fits[ax[1]]) begin
				pos[ax[0]] += mv[ax[0]];
				pos[ax[1]] += mv[ax[1]];
			end else if (fits[ax[0]]) begin
				pos[ax[0]] += mv[ax[0]];
				odir = h.only_a;
			end else if (fits[ax[1]]) begin
				pos[ax[1]] += mv[ax[1]];
				odir = h.only_b;
			end else begin
				odir = h.neither;
			end
		end
		flat = pos[0] + (pos[1] + pos[2] * GRID_Y) * GRID_X
			+ GRID_X * GRID_Y * GRID_Z * odir;
		res.x = COORD_W'(pos[0]);
		res.y = COORD_W'(pos[1]);
		res.z = COORD_W'(pos[2]);
		res.dir = DIR_W'(odir);
		res.idx = IDX_W'(flat);
		res.clamp = r.sample[SAMPLE_W-1] ? '0 : r.sample[CLAMP_W-1:0];
		return res;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		int e;
		// half the time a wall-adjacent value, otherwise anywhere
		if ($urandom_range(1)) begin
			e = $urandom_range(3);
			return (e < 2) ? COORD_W'(e) : COORD_W'(e + 12);
		end
		return COORD_W'($urandom_range(15));
	endfunction

	task automatic add_row(input logic [COORD_W-1:0] x, y, z, input logic [DIR_W-1:0] d,
			input logic [SAMPLE_W-1:0] s, input bit fixed, input dest_t want);
		plan_row_t row;
		row.req = '{sample: s, dir: d, z: z, y: y, x: x};
		row.fixed = fixed;
		row.want = want;
		plan.push_back(row);
	endtask

	// Holds the request until the DUT takes it; valid stays high afterwards so
	// back-to-back requests never drop it. The expectation is queued on accept.
	task automatic offer(input request_t r, input bit fixed, input dest_t want);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{PAD_W{1'b0}}, r};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_dest.push_back(fixed ? want : stream_dest(r));
	endtask

	// random sender gaps, about 38 in 100 unless in a calm stretch
	task automatic maybe_idle();
		if (!calm && $urandom_range(99) < 38) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Receiver: random back-pressure, a calm stretch, and a long counted
	// hold-off whenever stimulus asks for one.
	always @(posedge clk) begin
		if (stall_ask != stall_seen) begin
			stall_seen <= stall_ask;
			hold_left <= STALL_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (calm) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= 38);
		end
	end

	// Response checker: every accepted response pops the oldest expectation.
	always @(posedge clk) begin
		dest_t got;
		dest_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[64:0];
			if (pending_dest.size() == 0) begin
				$error("response with no request outstanding: %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_dest.pop_front();
				if (got.x !== want.x) begin
					$error("dest_x: expected %0d, got %0d", want.x, got.x);
					mismatches++;
				end
				if (got.y !== want.y) begin
					$error("dest_y: expected %0d, got %0d", want.y, got.y);
					mismatches++;
				end
				if (got.z !== want.z) begin
					$error("dest_z: expected %0d, got %0d", want.z, got.z);
					mismatches++;
				end
				if (got.dir !== want.dir) begin
					$error("dest_direction: expected %0d, got %0d", want.dir, got.dir);
					mismatches++;
				end
				if (got.idx !== want.idx) begin
					$error("dest_index: expected %0d, got %0d", want.idx, got.idx);
					mismatches++;
				end
				if (got.clamp !== want.clamp) begin
					$error("clamped_sample: expected %h, got %h", want.clamp, got.clamp);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: reports failure and stops a run that hangs.
	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		request_t r;
		// Directed requests. Typed expectations: rest at both corners, walls
		// at both corners, out-of-range codes, the largest index; the rest
		// go through the model, one per direction with a mix of wall cases.
		add_row(0, 0, 0, D_REST, 32'h0000_0000, 1, '{0, 0, D_REST, 0, 0, 0});
		add_row(15, 15, 15, D_REST, 32'h7FFF_FFFF, 1,
			'{31'h7FFF_FFFF, 4095, D_REST, 15, 15, 15});
		add_row(15, 15, 15, D_PX, 32'h8000_0000, 1, '{0, 12287, D_NX, 15, 15, 15});
		add_row(0, 0, 0, D_NX, 32'hFFFF_FFFF, 1, '{0, 4096, D_PX, 0, 0, 0});
		add_row(15, 15, 15, DIR_BAD_HI, 32'h0000_0001, 1, '{1, 4095, D_REST, 15, 15, 15});
		add_row(0, 0, 0, DIR_BAD_LO, 32'h1234_5678, 1,
			'{31'h1234_5678, 0, D_REST, 0, 0, 0});
		add_row(15, 14, 15, D_PYPZ, 32'h0000_0005, 1, '{5, 77823, D_PYNZ, 15, 15, 15});
		add_row(14, 2, 2, D_PX, 32'h0001_0000, 0, '0);
		add_row(0, 7, 7, D_NX, 32'hFFFF_0000, 0, '0);
		add_row(4, 15, 9, D_PY, 32'h5555_5555, 0, '0);
		add_row(4, 0, 9, D_NY, 32'hAAAA_AAAA, 0, '0);
		add_row(3, 3, 15, D_PZ, 32'h0000_8000, 0, '0);
		add_row(3, 3, 1, D_NZ, 32'h7FFF_0000, 0, '0);
		add_row(8, 8, 8, D_PXPY, 32'h0003_2000, 0, '0);
		add_row(0, 5, 5, D_NXNY, 32'h8000_0001, 0, '0);
		add_row(0, 15, 2, D_NXPY, 32'h0F0F_0F0F, 0, '0);
		add_row(14, 0, 2, D_PXNY, 32'hF0F0_F0F0, 0, '0);
		add_row(15, 9, 15, D_PXPZ, 32'h0000_0002, 0, '0);
		add_row(1, 1, 1, D_NXNZ, 32'h4000_0000, 0, '0);
		add_row(6, 15, 3, D_PYPZ, 32'h3333_3333, 0, '0);
		add_row(6, 4, 0, D_NYNZ, 32'hCCCC_CCCC, 0, '0);
		add_row(0, 6, 14, D_NXPZ, 32'h0000_FFFF, 0, '0);
		add_row(7, 7, 7, D_PXNZ, 32'hFFFE_0000, 0, '0);
		add_row(2, 0, 15, D_NYPZ, 32'h0010_0000, 0, '0);
		add_row(2, 14, 0, D_PYNZ, 32'h7FFF_FFFE, 0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			offer(plan[i].req, plan[i].fixed, plan[i].want);
			maybe_idle();
		end

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			// calm stretch: a full-rate run with no idling on either side
			calm = (n >= 300 && n < 450);
			// long receiver hold-off while requests keep coming, so the
			// pipe fills and s_axis_tready drops
			if (n == 600) stall_ask++;
			// sender pause until every response has come back
			if (n == 900) begin
				s_axis_tvalid <= 1'b0;
				wait (pending_dest.size() == 0);
				@(posedge clk);
			end
			r.x = pick_coord();
			r.y = pick_coord();
			r.z = pick_coord();
			r.dir = ($urandom_range(9) == 0) ? DIR_W'($urandom_range(31, 19))
				: DIR_W'($urandom_range(18));
			r.sample = $urandom;
			offer(r, 1'b0, '0);
			if (n < 600 || n > 640) maybe_idle();
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		wait (pending_dest.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== lattice_stream_boundary_map.f =====
hdl/lsbm_pkg.sv
hdl/lsbm_decode.sv
hdl/lsbm_move.sv
hdl/lsbm_index.sv
hdl/lattice_stream_boundary_map.sv
test/lattice_stream_boundary_map_tb.sv
